// ===== rtl/core/twspi_pkg.sv =====
// Package for the three-wire register bus master: field layout of the stream
// items, default sizes, phase constants and the item kind codes.
// No dependencies.
`default_nettype none

package twspi_pkg;

    // Default frame geometry
    localparam int unsigned DEF_DATA_BITS   = 16;
    localparam int unsigned DEF_HEADER_BITS = 9;
    localparam int unsigned DEF_TURN_BITS   = 2;
    localparam int unsigned TRAIL_BITS      = 2;

    // Header word layout
    localparam int unsigned ADDR_W        = 7;
    localparam int unsigned READ_FLAG_BIT = 7;

    // Fixed field widths
    localparam int unsigned WVAL_W = 16;
    localparam int unsigned RVAL_W = 16;

    // Input item: tdata layout, lowest bit first
    localparam int unsigned IN_TDATA_W = 32;
    localparam int unsigned IN_IS_READ = 0;
    localparam int unsigned IN_ADDR_LO = 1;
    localparam int unsigned IN_WVAL_LO = 8;
    localparam int unsigned IN_PIN     = 24;

    // Result item: tdata layout, lowest bit first
    localparam int unsigned OUT_TDATA_W = 24;
    localparam int unsigned OUT_SEL     = 0;
    localparam int unsigned OUT_CLK     = 1;
    localparam int unsigned OUT_DRIVE   = 2;
    localparam int unsigned OUT_PIN     = 3;
    localparam int unsigned OUT_BUSY    = 4;
    localparam int unsigned OUT_RVAL_LO = 5;
    localparam int unsigned OUT_REJ     = 21;

    // Item kind carried in tuser
    typedef enum logic {
        MODE_START = 1'b0,
        MODE_TICK  = 1'b1
    } t_mode;

endpackage : twspi_pkg

`default_nettype wire

// ===== rtl/core/three_wire_spi_register_master_unit.sv =====
// Three-wire register bus master, one result item per input item.
// Depends on twspi_pkg for field layout, defaults and item kind codes.
//
//  channel  | dir | handshake            | tdata / tuser / tlast
//  ---------+-----+----------------------+-----------------------------------
//  slave    | in  | i_s_tvalid/o_s_tready| start or tick item, kind in tuser
//  master   | out | o_m_tvalid/i_m_tready| bit-period result, tlast = final
//
// Cycles: one item is accepted per clock unless stalled; its result appears
// in the output register the next cycle. The state update and result logic
// form one short combinational pass (a counter step, a compare, a one-bit
// shift). Reset: synchronous, active low; clears the control state and the
// output valid. Stalls: while the output register holds an untaken result,
// the input is held off; it is taken in the same cycle the result leaves.
`default_nettype none

module three_wire_spi_register_master_unit
    import twspi_pkg::*;
#(
    parameter int unsigned DATA_BITS   = DEF_DATA_BITS,
    parameter int unsigned HEADER_BITS = DEF_HEADER_BITS,
    parameter int unsigned TURN_BITS   = DEF_TURN_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,

    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [0] is_read, [7:1] reg_address, [23:8] write_value, [24] pin_sample,
    // [31:25] zero
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [0] mode
    input  wire logic [0:0]             i_s_tuser,

    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [0] select_active, [1] clock_pulse, [2] pin_drive, [3] pin_out,
    // [4] busy_res, [20:5] read_value, [21] rejected, [23:22] zero
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    // last
    output logic                        o_m_tlast
);

    // Phase boundaries, counted in bit periods from the start item
    localparam int unsigned TOTAL_MAX = HEADER_BITS + TURN_BITS + DATA_BITS + TRAIL_BITS;
    localparam int unsigned POS_W     = $clog2(TOTAL_MAX + 1);
    localparam int unsigned SEND_W    = HEADER_BITS + DATA_BITS;

    localparam logic [POS_W-1:0] HDR_END  = POS_W'(HEADER_BITS);
    localparam logic [POS_W-1:0] RD_DATA0 = POS_W'(HEADER_BITS + TURN_BITS);
    localparam logic [POS_W-1:0] WR_DATA0 = POS_W'(HEADER_BITS);
    localparam logic [POS_W-1:0] DATA_LEN = POS_W'(DATA_BITS);
    localparam logic [POS_W-1:0] TAIL_LEN = POS_W'(TRAIL_BITS);

    // Transaction state
    logic [POS_W-1:0]     r_pos, n_pos;
    logic                 r_active, n_active;
    logic                 r_read, n_read;
    logic [SEND_W-1:0]    r_send, n_send;
    logic [DATA_BITS-1:0] r_recv, n_recv;

    // Output register
    logic                   r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata, n_m_tdata;
    logic                   r_m_tlast, n_m_tlast;

    // Unpacked input fields
    t_mode             in_mode;
    logic              in_is_read;
    logic [ADDR_W-1:0] in_addr;
    logic [WVAL_W-1:0] in_wval;
    logic              in_pin;

    // Result fields of the current item
    logic              res_sel, res_clk, res_drive, res_pin, res_busy, res_last, res_rej;
    logic [RVAL_W-1:0] res_rval;

    logic             s_accept;
    logic [POS_W-1:0] data_start, trail_start, total, pos_next;

    assign in_mode    = t_mode'(i_s_tuser[0]);
    assign in_is_read = i_s_tdata[IN_IS_READ];
    assign in_addr    = i_s_tdata[IN_ADDR_LO +: ADDR_W];
    assign in_wval    = i_s_tdata[IN_WVAL_LO +: WVAL_W];
    assign in_pin     = i_s_tdata[IN_PIN];

    // Take a new item whenever the output register is empty or draining
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // Turnaround only exists on reads
    assign data_start  = r_read ? RD_DATA0 : WR_DATA0;
    assign trail_start = data_start + DATA_LEN;
    assign total       = trail_start + TAIL_LEN;
    assign pos_next    = r_pos + POS_W'(1);

    always_comb begin
        n_pos    = r_pos;
        n_active = r_active;
        n_read   = r_read;
        n_send   = r_send;
        n_recv   = r_recv;

        res_sel   = 1'b0;
        res_clk   = 1'b0;
        res_drive = 1'b0;
        res_pin   = 1'b0;
        res_busy  = 1'b0;
        res_last  = 1'b0;
        res_rej   = 1'b0;
        res_rval  = '0;

        case (in_mode)
            MODE_START: begin
                res_busy = 1'b1;
                if (r_active) begin
                    // Drop the start, keep the running transaction
                    res_rej = 1'b1;
                end else begin
                    n_read   = in_is_read;
                    n_send   = {HEADER_BITS'({in_is_read, in_addr}), DATA_BITS'(in_wval)};
                    n_recv   = '0;
                    n_pos    = '0;
                    n_active = 1'b1;
                end
            end
            MODE_TICK: begin
                if (r_active) begin
                    res_clk = 1'b1;
                    if (r_pos < HDR_END) begin
                        // Address word, MSB first
                        res_sel   = 1'b1;
                        res_drive = 1'b1;
                        res_pin   = r_send[SEND_W-1];
                        n_send    = {r_send[SEND_W-2:0], 1'b0};
                    end else if (r_pos < data_start) begin
                        // Turnaround: pin released
                        res_sel = 1'b1;
                    end else if (r_pos < trail_start) begin
                        res_sel = 1'b1;
                        if (!r_read) begin
                            res_drive = 1'b1;
                            res_pin   = r_send[SEND_W-1];
                            n_send    = {r_send[SEND_W-2:0], 1'b0};
                        end
                        n_recv = {r_recv[DATA_BITS-2:0], in_pin};
                    end

                    if (pos_next >= total) begin
                        n_active = 1'b0;
                        n_pos    = '0;
                        res_last = 1'b1;
                        res_rval = RVAL_W'(n_recv);
                    end else begin
                        n_pos    = pos_next;
                        res_busy = 1'b1;
                    end
                end
            end
            default: begin
                res_busy = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_m_tdata = '0;
        n_m_tdata[OUT_SEL]                = res_sel;
        n_m_tdata[OUT_CLK]                = res_clk;
        n_m_tdata[OUT_DRIVE]              = res_drive;
        n_m_tdata[OUT_PIN]                = res_pin;
        n_m_tdata[OUT_BUSY]               = res_busy;
        n_m_tdata[OUT_RVAL_LO +: RVAL_W]  = res_rval;
        n_m_tdata[OUT_REJ]                = res_rej;
        n_m_tlast                         = res_last;

        // Hold the result until taken; refill on every accept
        if (s_accept) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_pos     <= '0;
            r_read    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            if (s_accept) begin
                r_active <= n_active;
                r_pos    <= n_pos;
                r_read   <= n_read;
            end
        end
    end

    // Shift registers and result payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_send    <= n_send;
            r_recv    <= n_recv;
            r_m_tdata <= n_m_tdata;
            r_m_tlast <= n_m_tlast;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

endmodule : three_wire_spi_register_master_unit

`default_nettype wire

// ===== rtl/core/twspi_checker.sv =====
// Port-level checks for the three-wire register bus master, bound to the top.
// Depends on twspi_pkg for the result field layout.
`default_nettype none

module twspi_checker
    import twspi_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_m_tvalid,
    input wire logic                   i_m_tready,
    input wire logic [OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic                   o_m_tlast
);

    // Final tick ends the transaction
    a_last_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> !o_m_tdata[OUT_BUSY])
        else $error("final tick still reports busy");

    // A dropped start issues no clock and keeps the bus state
    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OUT_REJ]) |->
            (o_m_tdata[OUT_BUSY] && !o_m_tdata[OUT_CLK] && !o_m_tlast))
        else $error("rejected start with clock or without busy");

    // The pin is only driven with select asserted and a clock issued
    a_drive_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OUT_DRIVE]) |->
            (o_m_tdata[OUT_SEL] && o_m_tdata[OUT_CLK]))
        else $error("pin driven outside select");

    // A clocked bit period is either mid-transaction or its end
    a_clock_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[OUT_CLK]) |-> (o_m_tdata[OUT_BUSY] || o_m_tlast))
        else $error("clock pulse with no transaction");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

endmodule : twspi_checker

bind three_wire_spi_register_master_unit twspi_checker u_twspi_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
